// ===== sv/lsg_pkg.sv =====
// ----------------------------------------------------------------------------
// lsg_pkg: shared types and constants of the LED strip gradient color block
// Q1.15 constants of the sRGB-like transfer, register indexes, defaults.
// ----------------------------------------------------------------------------
package lsg_pkg;

  localparam int Q15_W   = 16;
  localparam int ONE_Q15 = 32768;
  localparam int KNEE    = 102;
  localparam int OFFS    = 1802;
  localparam int HUE_W   = 9;
  localparam int IDX_W   = 7;
  localparam int COLOR_W = 24;

  localparam int DEF_LEDS_PER_SECTION = 16;
  localparam int DEF_SECTION_COUNT    = 7;
  localparam int DEF_GRADIENT_STEPS   = 112;

  localparam logic [1:0] REG_HUE_A      = 2'd0;
  localparam logic [1:0] REG_HUE_B      = 2'd1;
  localparam logic [1:0] REG_BRIGHTNESS = 2'd2;

  localparam logic [8:0] RST_HUE_A      = 9'd60;
  localparam logic [8:0] RST_HUE_B      = 9'd120;
  localparam logic [8:0] RST_BRIGHTNESS = 9'd256;

  // Encoded endpoint channels and the recompute status.
  typedef struct packed {
    logic                        busy;
    logic [2:0][Q15_W-1:0]       ea;
    logic [2:0][Q15_W-1:0]       eb;
  } endpt_t;

  // Picks one channel of an HSV color with saturation one.
  function automatic logic [Q15_W-1:0] chan_sel(input logic [2:0] sector,
                                                input logic [1:0] ch,
                                                input logic [Q15_W-1:0] v,
                                                input logic [Q15_W-1:0] x);
    logic [Q15_W-1:0] r, g, b;
    case (sector)
      3'd0: begin r = v; g = x; b = '0; end
      3'd1: begin r = x; g = v; b = '0; end
      3'd2: begin r = '0; g = v; b = x; end
      3'd3: begin r = '0; g = x; b = v; end
      3'd4: begin r = x; g = '0; b = v; end
      default: begin r = v; g = '0; b = x; end
    endcase
    case (ch)
      2'd0: chan_sel = r;
      2'd1: chan_sel = g;
      default: chan_sel = b;
    endcase
  endfunction

endpackage

// ===== sv/lsg_cdiv.sv =====
// ----------------------------------------------------------------------------
// lsg_cdiv: pipelined division by a constant
// Reciprocal multiply, back-multiply, one correction step; three stages.
// ----------------------------------------------------------------------------
module lsg_cdiv import lsg_pkg::*; #(
  parameter int W = 24,
  parameter int D = 112
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] x,
  output logic [W-1:0] q
);
  localparam int S = W + 1;
  localparam longint unsigned R = (64'd1 << S) / longint'(D);
  localparam int RW = $clog2(R + 1);
  localparam int DW = $clog2(D + 1);

  logic [W+RW-1:0] prod;
  logic [W-1:0]    x1, x2, q0;
  logic [W+DW-1:0] qd;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= (W+RW)'(x) * (W+RW)'(R);
      x1   <= x;
      q0   <= W'(prod >> S);
      qd   <= (W+DW)'(W'(prod >> S)) * (W+DW)'(D);
      x2   <= x1;
      // The estimate is at most one below the true quotient.
      q    <= ((W+DW)'(x2) - qd >= (W+DW)'(D)) ? q0 + W'(1) : q0;
    end
  end
endmodule

// ===== sv/lsg_cfg.sv =====
// ----------------------------------------------------------------------------
// lsg_cfg: register file and endpoint color sequencer
// Holds the hue and brightness registers and, after reset or any write,
// computes the six encoded endpoint channels with a serial square root and
// pipelined reciprocal dividers by constants.
// ----------------------------------------------------------------------------
module lsg_cfg import lsg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output endpt_t      ep
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_VMUL = 3'd1;
  localparam logic [2:0] ST_HUE  = 3'd2;
  localparam logic [2:0] ST_CHAN = 3'd3;
  localparam logic [2:0] ST_SQRT = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;

  localparam logic [1:0] MODE_X    = 2'd0;
  localparam logic [1:0] MODE_KNEE = 2'd1;
  localparam logic [1:0] MODE_ROOT = 2'd2;

  // Cycles from loading the dividend until the divider output is ready.
  localparam logic [4:0] DIV_WAIT = 5'd3;

  logic [8:0]  hue_a, hue_b, brightness;
  logic [2:0]  state, sector;
  logic [1:0]  mode, ch;
  logic        side;
  logic [15:0] v, x;
  logic [25:0] quo;
  logic [4:0]  cnt;
  logic [30:0] sq_n, sq_res, sq_bit;
  logic [2:0][15:0] ea, eb;

  logic        wr;
  logic [8:0]  hue_sel, h, b_cap;
  logic [2:0]  sector_c;
  logic [8:0]  r;
  logic [6:0]  t;
  logic [15:0] s_c, e_c;
  logic [25:0] q60, q1292, q1000;
  logic [25:0] q_fin;
  logic [30:0] sq_sum, sq_n_n, sq_res_n;
  logic [25:0] y;

  assign wr = psel && penable && pwrite;

  // One divider per constant; the sequencer picks the one for its mode.
  lsg_cdiv #(.W(26), .D(60))   u_div60   (.clk(clk), .en(1'b1), .x(quo), .q(q60));
  lsg_cdiv #(.W(26), .D(1292)) u_div1292 (.clk(clk), .en(1'b1), .x(quo), .q(q1292));
  lsg_cdiv #(.W(26), .D(1000)) u_div1000 (.clk(clk), .en(1'b1), .x(quo), .q(q1000));

  always_comb begin
    hue_sel = side ? hue_b : hue_a;
    h = (hue_sel >= 9'd360) ? hue_sel - 9'd360 : hue_sel;
    if (h >= 9'd300)      sector_c = 3'd5;
    else if (h >= 9'd240) sector_c = 3'd4;
    else if (h >= 9'd180) sector_c = 3'd3;
    else if (h >= 9'd120) sector_c = 3'd2;
    else if (h >= 9'd60)  sector_c = 3'd1;
    else                  sector_c = 3'd0;
    r = h - 9'(9'd60 * 9'(sector_c));
    t = sector_c[0] ? 7'(9'd60 - r) : 7'(r);
    b_cap = (brightness > 9'd256) ? 9'd256 : brightness;
    s_c = chan_sel(sector, ch, v, x);
    case (mode)
      MODE_KNEE: q_fin = q1292;
      MODE_ROOT: q_fin = q1000;
      default:   q_fin = q60;
    endcase
    sq_sum = sq_res + sq_bit;
    if (sq_n >= sq_sum) begin
      sq_n_n   = sq_n - sq_sum;
      sq_res_n = (sq_res >> 1) + sq_bit;
    end else begin
      sq_n_n   = sq_n;
      sq_res_n = sq_res >> 1;
    end
    y = (q_fin > 26'(OFFS)) ? q_fin - 26'(OFFS) : '0;
    if (mode == MODE_KNEE) e_c = q_fin[15:0];
    else e_c = (y > 26'(ONE_Q15)) ? 16'(ONE_Q15) : y[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hue_a      <= RST_HUE_A;
      hue_b      <= RST_HUE_B;
      brightness <= RST_BRIGHTNESS;
      state      <= ST_VMUL;
    end else begin
      if (wr) begin
        case (paddr[3:2])
          REG_HUE_A:      hue_a <= pwdata[8:0];
          REG_HUE_B:      hue_b <= pwdata[8:0];
          REG_BRIGHTNESS: brightness <= pwdata[8:0];
          default: ;
        endcase
        state <= ST_VMUL;
      end else begin
        case (state)
          ST_VMUL: begin
            v     <= 16'((18'(b_cap) * 18'(b_cap)) >> 1);
            side  <= 1'b0;
            state <= ST_HUE;
          end
          ST_HUE: begin
            sector  <= sector_c;
            quo     <= 26'(v) * 26'(t);
            cnt     <= '0;
            mode    <= MODE_X;
            state   <= ST_DIV;
          end
          ST_CHAN: begin
            if (s_c <= 16'(KNEE)) begin
              quo     <= 26'(s_c) * 26'd100 + 26'd646;
              cnt     <= '0;
              mode    <= MODE_KNEE;
              state   <= ST_DIV;
            end else begin
              sq_n   <= {s_c, 15'd0};
              sq_res <= '0;
              sq_bit <= 31'd1 << 30;
              cnt    <= '0;
              state  <= ST_SQRT;
            end
          end
          ST_SQRT: begin
            sq_n   <= sq_n_n;
            sq_res <= sq_res_n;
            sq_bit <= sq_bit >> 2;
            cnt    <= cnt + 5'd1;
            if (cnt == 5'd15) begin
              quo     <= 26'(sq_res_n) * 26'd1055 + 26'd500;
              cnt     <= '0;
              mode    <= MODE_ROOT;
              state   <= ST_DIV;
            end
          end
          ST_DIV: begin
            cnt <= cnt + 5'd1;
            if (cnt == DIV_WAIT) begin
              if (mode == MODE_X) begin
                x     <= q_fin[15:0];
                ch    <= 2'd0;
                state <= ST_CHAN;
              end else begin
                if (side) eb[ch] <= e_c;
                else      ea[ch] <= e_c;
                if (ch == 2'd2) begin
                  if (side) state <= ST_IDLE;
                  else begin
                    side  <= 1'b1;
                    state <= ST_HUE;
                  end
                end else begin
                  ch    <= ch + 2'd1;
                  state <= ST_CHAN;
                end
              end
            end
          end
          default: state <= ST_IDLE;
        endcase
      end
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_HUE_A:      prdata = {23'd0, hue_a};
      REG_HUE_B:      prdata = {23'd0, hue_b};
      REG_BRIGHTNESS: prdata = {23'd0, brightness};
      default:        prdata = '0;
    endcase
  end

  assign ep.busy = (state != ST_IDLE);
  assign ep.ea   = ea;
  assign ep.eb   = eb;
endmodule

// ===== sv/lsg_front.sv =====
// ----------------------------------------------------------------------------
// lsg_front: input acceptance, step lookup and item queue
// Maps each LED index to its gradient step through a constant table and
// queues it for the datapath.
// ----------------------------------------------------------------------------
module lsg_front import lsg_pkg::*; #(
  parameter int LEDS_PER_SECTION = DEF_LEDS_PER_SECTION,
  parameter int SECTION_COUNT    = DEF_SECTION_COUNT,
  parameter int GRADIENT_STEPS   = DEF_GRADIENT_STEPS,
  parameter int KW               = $clog2(DEF_GRADIENT_STEPS)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [IDX_W-1:0] led_index,
  input  logic             busy,
  input  logic             pop,
  output logic             head_valid,
  output logic             head_zero,
  output logic [KW-1:0]    head_k
);
  localparam int L   = LEDS_PER_SECTION;
  localparam int N   = GRADIENT_STEPS;
  localparam int DEN = L * (1 + SECTION_COUNT / 2);

  logic [KW-1:0] k_lut [2**IDX_W];
  logic          z_lut [2**IDX_W];

  for (genvar i = 0; i < 2**IDX_W; i++) begin : g_lut
    localparam int SEC  = i / L;
    localparam int P    = i % L;
    localparam int BASE = (SEC % 4 == 1) ? 0 : ((SEC % 4 == 2) ? 2 * L : L);
    localparam int POS  = (SEC / 4) * 2 * L + BASE + ((SEC % 2 == 1) ? 2 * P : -P);
    localparam int K0   = (2 * POS * (N - 1) + DEN) / (2 * DEN);
    localparam bit ZERO = (i >= L * SECTION_COUNT);
    localparam int K    = ZERO ? 0 : ((K0 > N - 1) ? N - 1 : K0);
    assign k_lut[i] = KW'(K);
    assign z_lut[i] = ZERO;
  end

  logic [KW-1:0] q_k [2];
  logic          q_z [2];
  logic          wptr, rptr;
  logic [1:0]    count;
  logic          push;

  assign in_stall   = busy || (count == 2'd2);
  assign push       = in_valid && !in_stall;
  assign head_valid = (count != 2'd0);
  assign head_k     = q_k[rptr];
  assign head_zero  = q_z[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_k[wptr] <= k_lut[led_index];
      q_z[wptr] <= z_lut[led_index];
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop)  rptr <= !rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

// ===== sv/lsg_back.sv =====
// ----------------------------------------------------------------------------
// lsg_back: gradient interpolation and decode pipeline
// Twelve stages per channel: lerp, divide by the step count, decode, scale.
// ----------------------------------------------------------------------------
module lsg_back import lsg_pkg::*; #(
  parameter int GRADIENT_STEPS = DEF_GRADIENT_STEPS,
  parameter int KW             = $clog2(DEF_GRADIENT_STEPS)
) (
  input  logic               clk,
  input  logic               rst,
  input  endpt_t             ep,
  input  logic               head_valid,
  input  logic               head_zero,
  input  logic [KW-1:0]      head_k,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COLOR_W-1:0] color_word
);
  localparam int N   = GRADIENT_STEPS;
  localparam int NW  = $clog2(N + 1);
  localparam int PW  = Q15_W + NW;
  localparam int SW  = PW + 1;
  localparam int AW  = 27;
  localparam int LAT = 12;

  logic [LAT-1:0] vld, zr;
  logic           en;
  logic [2:0][7:0] bytes;

  assign en  = !(vld[LAT-1] && out_stall);
  assign pop = en && head_valid;

  always_ff @(posedge clk) begin
    if (en) zr <= {zr[LAT-2:0], head_zero};
    if (rst) vld <= '0;
    else if (en) vld <= {vld[LAT-2:0], head_valid};
  end

  for (genvar c = 0; c < 3; c++) begin : g_lane
    logic [PW-1:0]   p1, p2;
    logic [SW-1:0]   sum, mq;
    logic [15:0]     m;
    logic            knee_c;
    logic [4:0]      kn;
    logic [AW-1:0]   ak, ar, qk, qr;
    logic [16:0]     w;
    logic [33:0]     ww;
    logic [18:0]     dr;
    logic [15:0]     kv, d;

    assign m      = 16'(mq);
    assign knee_c = (m <= 16'(KNEE));
    assign w      = 17'(qr);
    assign dr     = 19'((ww + 34'd16384) >> 15);

    always_ff @(posedge clk) begin
      if (en) begin
        p1  <= PW'(ep.ea[c]) * PW'(NW'(N) - NW'(head_k));
        p2  <= PW'(ep.eb[c]) * PW'(head_k);
        sum <= SW'(p1) + SW'(p2);
        kn  <= {kn[3:0], knee_c};
        ak  <= AW'(m) * AW'(1292) + AW'(50);
        ar  <= (AW'(m) + AW'(OFFS)) * AW'(1000) + AW'(527);
        ww  <= 34'(w) * 34'(w);
        kv  <= 16'(qk);
        d   <= kn[4] ? kv : ((dr > 19'(ONE_Q15)) ? 16'(ONE_Q15) : 16'(dr));
        bytes[c] <= 8'((24'(d) * 24'd255) >> 15);
      end
    end

    lsg_cdiv #(.W(SW), .D(N))    u_divn (.clk(clk), .en(en), .x(sum), .q(mq));
    lsg_cdiv #(.W(AW), .D(100))  u_divk (.clk(clk), .en(en), .x(ak),  .q(qk));
    lsg_cdiv #(.W(AW), .D(1055)) u_divr (.clk(clk), .en(en), .x(ar),  .q(qr));
  end

  assign out_valid  = vld[LAT-1];
  assign color_word = zr[LAT-1] ? '0 : {bytes[0], bytes[1], bytes[2]};
endmodule

// ===== sv/led_strip_gradient_color_top.sv =====
// ----------------------------------------------------------------------------
// led_strip_gradient_color_top: LED strip gradient color generator
// Gives the packed RGB color of one LED of a zigzag strip on a two-hue
// gradient.
// ----------------------------------------------------------------------------
// Usage. The input channel carries one LED index per beat (in_valid, in_stall,
// led_index); the output channel returns one packed color per beat
// (out_valid, out_stall, color_word: red 23:16, green 15:8, blue 7:0).
// Results come back in the order of the indexes.
// Throughput is one beat per cycle while the receiver does not stall and no
// recompute runs. An accepted input beat passes through the front queue and
// then the channel pipeline, whose depth is set by the three constant dividers and
// the decode squarer.
// The APB port writes hue_a at 0x0, hue_b at 0x4 and brightness at 0x8.
// After reset, and after every write, the endpoint sequencer recomputes the
// six encoded endpoint channels with a serial square root and pipelined
// constant dividers; in_stall is high while it runs.
// When the receiver stalls, the pipeline holds its result and stops; the
// two-entry front queue then fills and in_stall rises. Indexes past the end
// of the strip give a color of zero.
// ----------------------------------------------------------------------------
module led_strip_gradient_color_top import lsg_pkg::*; #(
  parameter int LEDS_PER_SECTION = DEF_LEDS_PER_SECTION,
  parameter int SECTION_COUNT    = DEF_SECTION_COUNT,
  parameter int GRADIENT_STEPS   = DEF_GRADIENT_STEPS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [IDX_W-1:0]   led_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COLOR_W-1:0] color_word
);
  // Step index width: enough for GRADIENT_STEPS - 1.
  localparam int KW = (GRADIENT_STEPS > 1) ? $clog2(GRADIENT_STEPS) : 1;

  endpt_t        ep;
  logic          pop, head_valid, head_zero;
  logic [KW-1:0] head_k;

  // Every access completes without wait states.
  assign pready = 1'b1;

  lsg_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .ep(ep)
  );

  // Front: accepts indexes, looks up the gradient step and queues it.
  lsg_front #(
    .LEDS_PER_SECTION(LEDS_PER_SECTION), .SECTION_COUNT(SECTION_COUNT),
    .GRADIENT_STEPS(GRADIENT_STEPS), .KW(KW)
  ) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .led_index(led_index), .busy(ep.busy), .pop(pop),
    .head_valid(head_valid), .head_zero(head_zero), .head_k(head_k)
  );

  // Back: interpolates the encoded channels and decodes them to bytes.
  lsg_back #(.GRADIENT_STEPS(GRADIENT_STEPS), .KW(KW)) u_back (
    .clk(clk), .rst(rst), .ep(ep), .head_valid(head_valid),
    .head_zero(head_zero), .head_k(head_k), .pop(pop),
    .out_valid(out_valid), .out_stall(out_stall), .color_word(color_word)
  );
endmodule

// ===== sv/lsg_checker.sv =====
// ----------------------------------------------------------------------------
// lsg_checker: port-level assertions for the gradient color block
// Checks reset behavior, recompute stalls and output holding.
// ----------------------------------------------------------------------------
module lsg_checker import lsg_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [COLOR_W-1:0] color_word
);
  // Nothing is in flight right after reset.
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat right after reset");

  // The endpoint recompute after reset blocks input.
  a_rst_busy: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input taken during recompute after reset");

  // A register write starts a recompute that blocks input.
  a_wr_busy: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite) |=> in_stall)
    else $error("input taken right after a register write");

  // A stalled output beat keeps its color.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(color_word)))
    else $error("stalled output beat changed");
endmodule

bind led_strip_gradient_color_top lsg_checker u_lsg_checker (
  .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
  .in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
  .color_word(color_word)
);

// ===== dv/led_strip_gradient_color_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_strip_gradient_color_top_tb: self-checking bench of the gradient block
// Writes hue and brightness settings over APB, then streams LED indexes with
// random gaps on both channels. Every returned color is compared with a
// predicted color that is computed from the current settings.
// ----------------------------------------------------------------------------
module led_strip_gradient_color_top_tb;
  import lsg_pkg::*;

  localparam int LPS    = DEF_LEDS_PER_SECTION;
  localparam int NSEC   = DEF_SECTION_COUNT;
  localparam int NSTEPS = DEF_GRADIENT_STEPS;
  localparam int CYCLE_LIMIT = 600000;
  // Margin waited after the last owed color is back, before new settings.
  localparam int DRAIN_CYCLES = 40;

  // Holds the register copy and the colors still owed by the block.
  class gradient_scoreboard;
    logic [8:0]  hue_a, hue_b, bright;
    logic [23:0] owed[$];

    function new();
      hue_a  = RST_HUE_A;
      hue_b  = RST_HUE_B;
      bright = RST_BRIGHTNESS;
    endfunction

    function void set_reg(logic [1:0] sel, logic [31:0] val);
      case (sel)
        REG_HUE_A:      hue_a  = val[8:0];
        REG_HUE_B:      hue_b  = val[8:0];
        REG_BRIGHTNESS: bright = val[8:0];
        default: ;
      endcase
    endfunction

    function automatic longint int_sqrt(longint n);
      longint res, bitv;
      res = 0;
      bitv = 64'd1 << 30;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n = n - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    // Square-root style transfer into the perceptual domain.
    function automatic longint to_perceptual(longint s);
      longint y;
      if (s > ONE_Q15) s = ONE_Q15;
      if (s <= KNEE) return (s * 100 + 646) / 1292;
      y = (int_sqrt(s << 15) * 1055 + 500) / 1000;
      y = (y > OFFS) ? y - OFFS : 0;
      return (y > ONE_Q15) ? ONE_Q15 : y;
    endfunction

    function automatic longint to_light(longint l);
      longint w, y;
      if (l > ONE_Q15) l = ONE_Q15;
      if (l <= KNEE) return (l * 1292 + 50) / 100;
      w = ((l + OFFS) * 1000 + 527) / 1055;
      y = (w * w + 16384) >> 15;
      return (y > ONE_Q15) ? ONE_Q15 : y;
    endfunction

    function automatic longint hue_channel(logic [8:0] hue, longint v, int ch);
      longint h, sector, r, t, x;
      longint rgb[3];
      h = hue % 360;
      sector = h / 60;
      r = h % 60;
      t = sector[0] ? 60 - r : r;
      x = (v * t) / 60;
      case (sector)
        0: rgb = '{v, x, 0};
        1: rgb = '{x, v, 0};
        2: rgb = '{0, v, x};
        3: rgb = '{0, x, v};
        4: rgb = '{x, 0, v};
        default: rgb = '{v, 0, x};
      endcase
      return rgb[ch];
    endfunction

    function automatic logic [23:0] led_color(logic [6:0] idx);
      longint section, p, pos, den, k, b, v, e1, e2, m, d;
      logic [23:0] word;
      word = '0;
      if (idx >= LPS * NSEC) return '0;
      section = idx / LPS;
      p = idx % LPS;
      pos = (section / 4) * 2 * LPS;
      case (section % 4)
        1: ;
        2: pos = pos + 2 * LPS;
        default: pos = pos + LPS;
      endcase
      pos = section[0] ? pos + 2 * p : pos - p;
      den = LPS * (1 + NSEC / 2);
      k = (2 * pos * (NSTEPS - 1) + den) / (2 * den);
      if (k > NSTEPS - 1) k = NSTEPS - 1;
      b = (bright > 256) ? 256 : bright;
      v = (b * b) >> 1;
      for (int ch = 0; ch < 3; ch++) begin
        e1 = to_perceptual(hue_channel(hue_a, v, ch));
        e2 = to_perceptual(hue_channel(hue_b, v, ch));
        m = (e1 * (NSTEPS - k) + e2 * k) / NSTEPS;
        d = to_light(m);
        word = {word[15:0], 8'((d * 255) >> 15)};
      end
      return word;
    endfunction

    function void note_index(logic [6:0] idx);
      owed.push_back(led_color(idx));
    endfunction

    // 0: match, 1: wrong color, 2: nothing was owed.
    function int check_color(logic [23:0] got, output logic [23:0] want);
      want = 'x;
      if (owed.size() == 0) return 2;
      want = owed.pop_front();
      return (got === want) ? 0 : 1;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [6:0]  led_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [23:0] color_word;

  led_strip_gradient_color_top uut (.*);

  gradient_scoreboard colors = new();
  int  errors = 0;
  int  colors_checked = 0;
  int  indexes_sent = 0;
  int  settings_used = 0;
  int  cycles = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report(input string what, input logic [23:0] got,
                        input logic [23:0] want);
    errors++;
    $display("MISMATCH %s: got %06h want %06h at %0t", what, got, want, $realtime);
  endtask

  // The receiver stalls at random; the rate changes with the phase.
  always @(negedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < recv_stall_pct);
  end

  // Output beats are checked at the rising edge, in order.
  always @(posedge clk) begin
    logic [23:0] want;
    int verdict;
    cycles <= cycles + 1;
    if (!rst && out_valid && !out_stall) begin
      verdict = colors.check_color(color_word, want);
      colors_checked++;
      if (verdict == 2) report("color with none owed", color_word, want);
      else if (verdict == 1) report("color", color_word, want);
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // Sends one index beat. Valid stays high from one beat to the next unless
  // the random gap lowers it, so it is never dropped and raised in one step.
  task automatic send_index(input logic [6:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      led_index <= 7'($urandom);
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    led_index <= idx;
    do @(posedge clk); while (!(in_valid && !in_stall));
    colors.note_index(idx);
    indexes_sent++;
    @(negedge clk);
  endtask

  // Waits until every owed color is back and the pipeline has settled.
  task automatic drain();
    in_valid <= 1'b0;
    while (colors.owed.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // APB write: setup cycle, then access cycle; pready is always high.
  task automatic write_reg(input logic [1:0] sel, input logic [8:0] val);
    logic [31:0] word;
    word = {$urandom} & 32'hFFFF_FE00 | 32'(val);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {sel, 2'b00}; pwdata <= word;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    colors.set_reg(sel, word);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic apply_setting(input logic [8:0] ha, input logic [8:0] hb,
                               input logic [8:0] br);
    drain();
    write_reg(REG_HUE_A, ha);
    write_reg(REG_HUE_B, hb);
    write_reg(REG_BRIGHTNESS, br);
    settings_used++;
  endtask

  initial begin
    logic [6:0] directed[$];
    logic [8:0] hues[$];
    logic [8:0] brights[$];
    int total;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed pass at the reset settings: both ends, section borders of the
    // zigzag, and indexes past the last LED.
    directed = '{0, 1, 15, 16, 17, 31, 32, 47, 48, 63, 64, 79, 80, 95, 96,
                 110, 111, 112, 113, 127, 85, 42};
    foreach (directed[i]) send_index(directed[i]);

    // Extremes: hues at the sector edges 0, 60, 180, 240 and 300, beside them and
    // past 360, brightness zero, tiny, full and above full.
    hues    = '{0, 59, 60, 180, 300, 359, 360, 511, 419, 240};
    brights = '{0, 1, 256, 511, 128, 300, 16, 200, 64, 256};
    total = 0;
    for (int s = 0; s < 10; s++) begin
      apply_setting(hues[s], hues[(s + 3) % 10], brights[s]);
      for (int n = 0; n < 160; n++) begin
        // The idling pattern follows the share of the run done so far.
        if (total < 530) begin
          send_idle_pct = 34; recv_stall_pct = 74;
        end else if (total < 1060) begin
          send_idle_pct = 74; recv_stall_pct = 34;
        end else begin
          send_idle_pct = 0; recv_stall_pct = 0;
        end
        // Mostly LEDs on the strip, some past its end.
        send_index(($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(111)));
        total++;
      end
    end

    drain();
    $display("Sent %0d LED indexes over %0d register settings; checked %0d colors.",
             indexes_sent, settings_used, colors_checked);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
